// ===== sv/tpdm_pkg.sv =====
// Shared types and constants for the tach period and duty meter.
// No dependencies; imported by the top level.
package tpdm_pkg;

	localparam int CFG_COUNTER_BITS = 16;

	localparam int LIMIT_W   = 16;
	localparam int RATE_W    = 24;
	localparam int DUTY_W    = 17;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [LIMIT_W-1:0] OVERFLOW_LIMIT_RESET = 16'hFFFF;
	localparam logic [RATE_W-1:0]  TICK_RATE_RESET     = 24'd100000;
	localparam logic [DUTY_W-1:0]  DUTY_FULL           = 17'd65536;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OVERFLOW_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE      = 1'b1;

	// input function codes
	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_REARM = 1'b1;

	// measurement phase codes; the unused code behaves as waiting for a rising edge
	localparam logic [1:0] PH_WAIT_RISE = 2'd1;
	localparam logic [1:0] PH_WAIT_FALL = 2'd2;
	localparam logic [1:0] PH_WAIT_END  = 2'd3;

	typedef struct packed {
		logic func;
		logic level;
	} tpdm_in_t;

	typedef struct packed {
		logic [RATE_W-1:0] freq_hz;
		logic [DUTY_W-1:0] duty_frac;
		logic              done_res;
	} tpdm_out_t;

endpackage

// ===== sv/tpdm_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; instantiated by the tach period and duty meter top level.
module tpdm_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] shifted;
	logic [DEN_W:0] diff;
	logic           fits;

	assign shifted = {rem_q, num_q[NUM_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = ~diff[DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// quotient bits shift in behind the numerator bits
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = num_q;

endmodule

// ===== sv/tach_period_duty_meter_unit.sv =====
// Tach period and duty meter: edge sequencer with a shared serial divider.
// A plain tick or rearm item goes from S_IDLE to S_OUT, then into the output register once it is free.
// A tick that completes a measurement first passes S_DIVF and S_DIVD, two passes of the
// one-bit-per-cycle divider: frequency, then duty.
// One item at a time; a new item is taken once the previous result is in the output register.
// Reset (arst_n low) clears the phase, counters, results and output valid at once.
module tach_period_duty_meter_unit
	import tpdm_pkg::*;
#(
	parameter int COUNTER_BITS = CFG_COUNTER_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tpdm_in_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output tpdm_out_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CB    = COUNTER_BITS;
	localparam int NUM_W = COUNTER_BITS + 17;
	localparam int DEN_W = COUNTER_BITS + 1;
	localparam int CMP_W = (COUNTER_BITS + 1 > LIMIT_W + 1) ? COUNTER_BITS + 1 : LIMIT_W + 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIVF = 4'b0010,
		S_DIVD = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [RATE_W-1:0]  rate_q;
	logic [1:0]         phase_q;
	logic [CB-1:0]      tick_q;
	logic [CB-1:0]      high_q;
	logic               prev_q;
	logic               done_q;
	logic [RATE_W-1:0]  freq_q;
	logic [DUTY_W-1:0]  duty_q;
	logic [DEN_W-1:0]   den_q;
	tpdm_out_t          out_q;
	logic               out_valid_q;

	// next-tick values
	logic               accept;
	logic               rising;
	logic               falling;
	logic               cleared;
	logic               finish;
	logic               timeout;
	logic [DEN_W-1:0]   next_cnt;
	logic [1:0]         phase_n;
	logic [CB-1:0]      tick_n;
	logic [CB-1:0]      high_n;

	// divider hookup
	logic               div_start;
	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic               div_busy;
	logic               div_done;
	logic [NUM_W-1:0]   div_quot;
	logic [NUM_W-1:0]   duty_num;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	// Handle edges against the previous level first, then advance the counter
	// unless the first rising edge has just zeroed it.
	always_comb begin
		rising   = in_data.level && !prev_q;
		falling  = !in_data.level && prev_q;
		cleared  = 1'b0;
		finish   = 1'b0;
		phase_n  = phase_q;
		high_n   = high_q;
		tick_n   = tick_q;
		next_cnt = {1'b0, tick_q} + DEN_W'(1);
		if (!done_q) begin
			case (phase_q)
				PH_WAIT_FALL: begin
					if (falling) begin
						high_n  = tick_q;
						phase_n = PH_WAIT_END;
					end
				end
				PH_WAIT_END: begin
					if (rising) begin
						phase_n = PH_WAIT_RISE;
						finish  = 1'b1;
					end
				end
				default: begin
					if (rising) begin
						phase_n = PH_WAIT_FALL;
						tick_n  = '0;
						cleared = 1'b1;
					end
				end
			endcase
		end
		timeout = !cleared &&
			((CMP_W'(next_cnt) >= CMP_W'(limit_q)) || next_cnt[CB]);
		if (!cleared) begin
			tick_n = timeout ? '0 : next_cnt[CB-1:0];
		end
		if (timeout) begin
			phase_n = PH_WAIT_RISE;
		end
	end

	// Frequency pass starts straight from the accepting cycle; duty pass follows it.
	assign duty_num  = {({1'b0, high_q} + DEN_W'(1)), 16'b0};
	assign div_start = (accept && in_data.func == FUNC_TICK && finish && !timeout) ||
		(state_q == S_DIVF && div_done);
	assign div_num   = (state_q == S_DIVF) ? duty_num : NUM_W'(rate_q);
	assign div_den   = (state_q == S_IDLE) ? next_cnt : den_q;

	tpdm_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	// configuration registers: the user must write them only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= OVERFLOW_LIMIT_RESET;
			rate_q  <= TICK_RATE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OVERFLOW_LIMIT: limit_q <= cfg_data[LIMIT_W-1:0];
				REG_TICK_RATE:      rate_q  <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_WAIT_RISE;
			tick_q      <= '0;
			high_q      <= '0;
			prev_q      <= 1'b0;
			done_q      <= 1'b0;
			freq_q      <= '0;
			duty_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_data.func == FUNC_REARM) begin
							// rearm: clear done only
							done_q  <= 1'b0;
							state_q <= S_OUT;
						end else begin
							phase_q <= phase_n;
							tick_q  <= tick_n;
							high_q  <= high_n;
							prev_q  <= in_data.level;
							if (timeout) begin
								// timeout wins over a completion on the same tick
								freq_q  <= '0;
								duty_q  <= '0;
								done_q  <= 1'b1;
								state_q <= S_OUT;
							end else if (finish) begin
								done_q  <= 1'b1;
								state_q <= S_DIVF;
							end else begin
								state_q <= S_OUT;
							end
						end
					end
				end
				S_DIVF: begin
					if (div_done) begin
						freq_q  <= div_quot[RATE_W-1:0];
						state_q <= S_DIVD;
					end
				end
				S_DIVD: begin
					if (div_done) begin
						// saturate duty at one
						duty_q  <= (div_quot > NUM_W'(DUTY_FULL)) ?
							DUTY_FULL : div_quot[DUTY_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// hold until the output register is free or being drained
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// period plus one, kept for the duty pass
	always_ff @(posedge clk) begin
		if (accept) begin
			den_q <= next_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_q.freq_hz   <= freq_q;
			out_q.duty_frac <= duty_q;
			out_q.done_res  <= done_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIVF || state_q == S_DIVD))
		else $error("divider finished outside a division state");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		duty_q <= DUTY_FULL)
		else $error("duty result above full scale");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("second item taken before the result was stored");

	a_done_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVD && div_done) |=> done_q)
		else $error("done flag clear after a completed measurement");
`endif

endmodule
